FILE: hdl/allm_pkg.sv
// Shared types and constants for the array linked list manager.
// Holds action and status codes, port widths and the controller/datapath interface.
// No dependencies.
package allm_pkg;

	// Default sizes of the slot table.
	localparam int SLOTS_DEF     = 64;
	localparam int DATA_BITS_DEF = 32;

	// Fixed widths of the request and result ports.
	localparam int ACT_W   = 3;
	localparam int VALUE_W = 32;
	localparam int SLOT_W  = 6;
	localparam int STS_W   = 3;
	localparam int COUNT_W = 6;

	// Request codes.
	typedef enum logic [ACT_W-1:0] {
		ACT_INS_FIRST = 3'd0,
		ACT_INS_AFTER = 3'd1,
		ACT_INS_LAST  = 3'd2,
		ACT_SEARCH    = 3'd3,
		ACT_DEL_NEXT  = 3'd4
	} action_t;

	// Result status codes.
	typedef enum logic [STS_W-1:0] {
		STS_OK        = 3'd0,
		STS_BAD_SLOT  = 3'd1,
		STS_NO_DEL    = 3'd2,
		STS_FULL      = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	// Operation class of the request held in the datapath.
	typedef enum logic [1:0] {
		OPK_NONE,
		OPK_INS,
		OPK_SRCH,
		OPK_DEL
	} op_kind_t;

	// Commands from the controller to the datapath.
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_EXEC,
		CMD_SRCH,
		CMD_DEL,
		CMD_WR2
	} dp_cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		op_kind_t opk;       // class of the current request
		logic     exec_more; // first step needs a follow-up step
		logic     step_end;  // search walk ends in this cycle
		logic     del_wr2;   // delete must relink a predecessor slot
		logic     clr_last;  // clearing pass is at its last slot
	} dp_stat_t;

endpackage

FILE: hdl/allm_dp.sv
// Datapath of the array linked list manager: link and payload memories,
// list pointers, element count and result registers.
// Depends on allm_pkg.
module allm_dp import allm_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	input  logic [ACT_W-1:0]          action,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [SLOT_W-1:0]         slot,
	output logic [STS_W-1:0]          status,
	output logic [SLOT_W-1:0]         found_slot,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [COUNT_W-1:0]        count
);

	localparam int IDX_W = $clog2(SLOTS);

	// One link table entry: in-list mark and successor slot.
	typedef struct packed {
		logic             used;
		logic [IDX_W-1:0] nxt;
	} entry_t;

	// Memories.
	entry_t               link_mem [SLOTS];
	logic [DATA_BITS-1:0] pay_mem  [SLOTS];

	// List state.
	logic [IDX_W-1:0] head_q, tail_q, free_q, cnt_q, clr_idx_q;

	// Request and working registers.
	logic [ACT_W-1:0]     act_q;
	logic [DATA_BITS-1:0] val_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [IDX_W-1:0]     cur_q;
	logic [IDX_W-1:0]     pend_addr_q;
	entry_t               pend_data_q;

	// Result registers.
	status_t              status_q;
	logic [IDX_W-1:0]     found_q;
	logic [DATA_BITS-1:0] removed_q;

	// Registered read data.
	entry_t               rd_link_q;
	entry_t               rd_free_q;
	logic [DATA_BITS-1:0] rd_pay_q;

	// Decode and per-step conditions.
	op_kind_t         opk;
	logic [IDX_W-1:0] s_idx, tgt, rd_addr;
	logic             s_zero, s_valid, full, empty;
	logic             ins_bad, ins_ok, after_mid, is_last, del_bad, match;
	logic             lk_we, pay_we;
	logic [IDX_W-1:0] lk_waddr;
	entry_t           lk_wdata;

	// Classify the held request.
	always_comb begin
		priority case (act_q)
			ACT_INS_FIRST, ACT_INS_AFTER, ACT_INS_LAST: opk = OPK_INS;
			ACT_SEARCH:                                 opk = OPK_SRCH;
			ACT_DEL_NEXT:                               opk = OPK_DEL;
			default:                                    opk = OPK_NONE;
		endcase
	end

	// Conditions shared by the insert, delete and search steps.
	assign s_idx     = IDX_W'(slot_q);
	assign s_zero    = (slot_q == '0);
	assign s_valid   = s_zero || ((int'(slot_q) < SLOTS) && rd_link_q.used);
	assign full      = (free_q == '0);
	assign empty     = (cnt_q == '0);
	assign ins_bad   = (act_q == ACT_INS_AFTER) && !s_valid;
	assign ins_ok    = !ins_bad && !full;
	assign after_mid = (act_q == ACT_INS_AFTER) && !s_zero;
	assign is_last   = (act_q == ACT_INS_LAST);
	assign tgt       = s_zero ? head_q : rd_link_q.nxt;
	assign del_bad   = !s_valid || (tgt == '0) || empty;
	assign match     = (rd_pay_q == val_q);

	// Status toward the controller.
	always_comb begin
		stat.opk      = opk;
		stat.step_end = match || (rd_link_q.nxt == '0);
		stat.del_wr2  = !s_zero;
		stat.clr_last = (clr_idx_q == IDX_W'(SLOTS - 1));
		unique case (opk)
			OPK_INS:  stat.exec_more = ins_ok && (after_mid || (is_last && !empty));
			OPK_SRCH: stat.exec_more = (head_q != '0);
			OPK_DEL:  stat.exec_more = !del_bad;
			OPK_NONE: stat.exec_more = 1'b0;
		endcase
	end

	// Read address shared by the link and payload memories.
	always_comb begin
		unique case (cmd)
			CMD_LOAD: rd_addr = IDX_W'(slot);
			CMD_EXEC: rd_addr = (opk == OPK_SRCH) ? head_q : tgt;
			CMD_SRCH: rd_addr = rd_link_q.nxt;
			default:  rd_addr = cur_q;
		endcase
	end

	// Link memory write port.
	always_comb begin
		lk_we    = 1'b0;
		lk_waddr = cur_q;
		lk_wdata = pend_data_q;
		pay_we   = (cmd == CMD_EXEC) && (opk == OPK_INS) && ins_ok;
		unique case (cmd)
			CMD_CLEAR: begin
				lk_we         = 1'b1;
				lk_waddr      = clr_idx_q;
				lk_wdata.used = 1'b0;
				lk_wdata.nxt  = stat.clr_last ? '0 : clr_idx_q + IDX_W'(1);
			end
			CMD_EXEC: begin
				lk_we         = pay_we;
				lk_waddr      = free_q;
				lk_wdata.used = 1'b1;
				if (after_mid) begin
					lk_wdata.nxt = rd_link_q.nxt;
				end else if (is_last || empty) begin
					lk_wdata.nxt = '0;
				end else begin
					lk_wdata.nxt = head_q;
				end
			end
			CMD_DEL: begin
				lk_we         = 1'b1;
				lk_waddr      = cur_q;
				lk_wdata.used = 1'b0;
				lk_wdata.nxt  = free_q;
			end
			CMD_WR2: begin
				lk_we    = 1'b1;
				lk_waddr = pend_addr_q;
			end
			default: begin
				lk_we = 1'b0;
			end
		endcase
	end

	// Link memory: one write, a read at the shared address and at the free head.
	always_ff @(posedge clk) begin
		if (lk_we) begin
			link_mem[lk_waddr] <= lk_wdata;
		end
		rd_link_q <= link_mem[rd_addr];
		rd_free_q <= link_mem[free_q];
	end

	// Payload memory.
	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[free_q] <= val_q;
		end
		rd_pay_q <= pay_mem[rd_addr];
	end

	// List pointers, count and clearing index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			free_q    <= IDX_W'(1);
			cnt_q     <= '0;
			clr_idx_q <= '0;
		end else begin
			unique case (cmd)
				CMD_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
				end
				CMD_EXEC: begin
					if ((opk == OPK_INS) && ins_ok) begin
						free_q <= rd_free_q.nxt;
						cnt_q  <= cnt_q + IDX_W'(1);
						if (after_mid) begin
							if (tail_q == s_idx) begin
								tail_q <= free_q;
							end
						end else if (is_last) begin
							if (empty) begin
								head_q <= free_q;
							end
							tail_q <= free_q;
						end else begin
							head_q <= free_q;
							if (empty) begin
								tail_q <= free_q;
							end
						end
					end
				end
				CMD_DEL: begin
					free_q <= cur_q;
					cnt_q  <= cnt_q - IDX_W'(1);
					if (cnt_q == IDX_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						if (s_zero) begin
							head_q <= rd_link_q.nxt;
						end
						if (tail_q == cur_q) begin
							tail_q <= s_idx;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request capture, walk pointer, deferred write and result registers.
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				act_q     <= action;
				val_q     <= DATA_BITS'($unsigned(value));
				slot_q    <= slot;
				status_q  <= STS_OK;
				found_q   <= '0;
				removed_q <= '0;
			end
			CMD_EXEC: begin
				cur_q <= rd_addr;
				unique case (opk)
					OPK_INS: begin
						if (ins_bad) begin
							status_q <= STS_BAD_SLOT;
						end else if (full) begin
							status_q <= STS_FULL;
						end else begin
							found_q <= free_q;
						end
						pend_addr_q      <= after_mid ? s_idx : tail_q;
						pend_data_q.used <= 1'b1;
						pend_data_q.nxt  <= free_q;
					end
					OPK_SRCH: begin
						if (head_q == '0) begin
							status_q <= STS_NOT_FOUND;
						end
					end
					OPK_DEL: begin
						if (del_bad) begin
							status_q <= STS_NO_DEL;
						end
					end
					OPK_NONE: begin
					end
				endcase
			end
			CMD_SRCH: begin
				cur_q <= rd_addr;
				if (match) begin
					found_q <= cur_q;
				end else if (rd_link_q.nxt == '0) begin
					status_q <= STS_NOT_FOUND;
				end
			end
			CMD_DEL: begin
				removed_q        <= rd_pay_q;
				pend_addr_q      <= s_idx;
				pend_data_q.used <= 1'b1;
				pend_data_q.nxt  <= rd_link_q.nxt;
			end
			default: begin
			end
		endcase
	end

	// Result ports.
	assign status        = status_q;
	assign found_slot    = SLOT_W'(found_q);
	assign removed_value = VALUE_W'(removed_q);
	assign count         = COUNT_W'(cnt_q);

endmodule

FILE: hdl/allm_ctrl.sv
// Controller of the array linked list manager: sequences the clearing pass
// and the steps of each request, and drives busy and done.
// Depends on allm_pkg.
module allm_ctrl import allm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SRCH,
		ST_DEL,
		ST_WR2
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, done_q, done_d;

	// Next state and datapath command.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = CMD_NOP;
		unique case (state_q)
			ST_CLEAR: begin
				cmd = CMD_CLEAR;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd     = CMD_LOAD;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd = CMD_EXEC;
				if (stat.exec_more && (stat.opk == OPK_INS)) begin
					state_d = ST_WR2;
				end else if (stat.exec_more && (stat.opk == OPK_SRCH)) begin
					state_d = ST_SRCH;
				end else if (stat.exec_more && (stat.opk == OPK_DEL)) begin
					state_d = ST_DEL;
				end else begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			ST_SRCH: begin
				cmd = CMD_SRCH;
				if (stat.step_end) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			ST_DEL: begin
				cmd = CMD_DEL;
				if (stat.del_wr2) begin
					state_d = ST_WR2;
				end else begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			ST_WR2: begin
				cmd     = CMD_WR2;
				state_d = ST_IDLE;
				done_d  = 1'b1;
			end
		endcase
	end

	// State and registered handshake outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= done_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: hdl/array_linked_list_manager_core.sv
// Top level of the array linked list manager.
// Depends on allm_pkg, allm_ctrl and allm_dp.
//
// A singly linked list kept in a table of SLOTS slots with a free list;
// slot 0 is the end marker. A request (action, value, slot) is
// transferred at a rising edge where start is high and busy is low.
// Its result (status, found_slot, removed_value, count) is on the result
// ports, marked by done, which is high for a single cycle; the receiver cannot stall,
// so every result is transferred in the cycle it appears.
// Each request passes the controller state EXEC, where one that fails its
// checks ends; then WR2 for an insert that relinks a predecessor slot, DEL
// and, when a predecessor slot is relinked, WR2 for a delete, or SRCH for a
// search, which walks the list one slot per cycle through the link
// memory's registered read port.
// busy is high from the transfer until done; one request at a time.
// After reset the block sweeps all SLOTS slots of the link table, one slot
// per cycle, with busy high, before the first request is taken.
module array_linked_list_manager_core import allm_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ACT_W-1:0]          action,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [SLOT_W-1:0]         slot,
	output logic                      done,
	output logic [STS_W-1:0]          status,
	output logic [SLOT_W-1:0]         found_slot,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [COUNT_W-1:0]        count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	allm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Memories, list pointers and result registers.
	allm_dp #(
		.SLOTS     (SLOTS),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.value         (value),
		.slot          (slot),
		.status        (status),
		.found_slot    (found_slot),
		.removed_value (removed_value),
		.count         (count)
	);

	// A result is never shown while a request is still in progress.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// A transferred request raises busy, without done, and holds off further requests.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("request transfer not followed by busy");

	// A failed request reports no slot.
	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STS_OK)) |-> (found_slot == '0))
		else $error("failed request reports a slot");

endmodule
